// ===== hw/rtl/ctf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctf_pkg
// Request kinds, status codes and fixed field widths of the file table.
// ----------------------------------------------------------------------------
package ctf_pkg;

    localparam int KIND_W   = 2;
    localparam int NAME_W   = 32;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEFRAG = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

endpackage

// ===== hw/rtl/ctf_mem.sv =====
// ----------------------------------------------------------------------------
// ctf_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ctf_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 56
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/contiguous_file_table.sv =====
// ----------------------------------------------------------------------------
// contiguous_file_table
// Ordered file table with add, delete by key and defragment requests.
// ----------------------------------------------------------------------------
// Flow: add and unused kinds pass from input transfer to the done state, then
//   to the result register once it is free; delete and defragment first scan
//   the table, one entry read per cycle from the single read port of the entry store.
// Throughput: one request at a time; the next is taken in the cycle after the
//   result is loaded into the output register.
// Reset: synchronous, active low; table empty, free space zero, no clearing pass.
module contiguous_file_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ctf_pkg::SIZE_W-1:0]          i_cfg_data,
    // requests
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ctf_pkg::KIND_W-1:0]          i_kind,
    input  logic [ctf_pkg::NAME_W-1:0]          i_name_key,
    input  logic [ctf_pkg::SIZE_W-1:0]          i_file_size,
    // results
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ctf_pkg::STATUS_W-1:0]        o_status,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    o_assigned_id,
    output logic [ctf_pkg::SIZE_W-1:0]          o_space_left,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    o_entry_count
);

    import ctf_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    // entry word: {live, id, key, size}
    localparam int WORD_W = 1 + CNT_W + KEY_BITS + SIZE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [SIZE_W-1:0]     r_free, n_free;
    logic                  r_is_del, n_is_del;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [CNT_W-1:0]      r_rd_addr, n_rd_addr;
    logic                  r_pend, n_pend;
    logic [IDX_W-1:0]      r_proc_idx, n_proc_idx;
    logic [CNT_W-1:0]      r_wr, n_wr;
    logic                  r_found, n_found;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [CNT_W-1:0]      r_res_id, n_res_id;
    logic                  r_o_valid, n_o_valid;
    logic [STATUS_W-1:0]   r_o_status, n_o_status;
    logic [CNT_W-1:0]      r_o_id, n_o_id;
    logic [SIZE_W-1:0]     r_o_space, n_o_space;
    logic [CNT_W-1:0]      r_o_count, n_o_count;

    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [WORD_W-1:0]     w_wdata;
    logic [WORD_W-1:0]     w_rdata;
    logic [KEY_BITS-1:0]   w_in_key;
    logic [SIZE_W-1:0]     w_rd_size;
    logic [KEY_BITS-1:0]   w_rd_key;
    logic                  w_rd_live;
    logic [SIZE_W:0]       w_sum;
    logic                  w_in_acc;

    ctf_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_addr[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_in_key  = KEY_BITS'(i_name_key);
    assign w_rd_size = w_rdata[SIZE_W-1:0];
    assign w_rd_key  = w_rdata[SIZE_W +: KEY_BITS];
    assign w_rd_live = w_rdata[WORD_W-1];
    assign w_sum     = {1'b0, r_free} + {1'b0, w_rd_size};

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_free       = r_free;
        n_is_del     = r_is_del;
        n_key        = r_key;
        n_rd_addr    = r_rd_addr;
        n_pend       = r_pend;
        n_proc_idx   = r_proc_idx;
        n_wr         = r_wr;
        n_found      = r_found;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_id       = r_o_id;
        n_o_space    = r_o_space;
        n_o_count    = r_o_count;
        w_we         = 1'b0;
        w_waddr      = r_count[IDX_W-1:0];
        w_wdata      = {1'b1, r_count + 1'b1, w_in_key, i_file_size};

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res_status = ST_OK;
                    n_res_id     = '0;
                    n_state      = S_DONE;
                    case (i_kind)
                        KIND_ADD: begin
                            // full check comes before the space check
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else if (i_file_size > r_free) begin
                                n_res_status = ST_NO_SPACE;
                            end else begin
                                w_we     = 1'b1;
                                n_free   = r_free - i_file_size;
                                n_count  = r_count + 1'b1;
                                n_res_id = r_count + 1'b1;
                            end
                        end
                        KIND_DELETE, KIND_DEFRAG: begin
                            n_state   = S_SCAN;
                            n_is_del  = (i_kind == KIND_DELETE);
                            n_key     = w_in_key;
                            n_rd_addr = '0;
                            n_pend    = 1'b0;
                            n_wr      = '0;
                            n_found   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // process the entry read last cycle
                if (r_pend) begin
                    if (r_is_del) begin
                        if (w_rd_live && (w_rd_key == r_key)) begin
                            w_we    = 1'b1;
                            w_waddr = r_proc_idx;
                            w_wdata = {1'b0, w_rdata[WORD_W-2:0]};
                            n_free  = w_sum[SIZE_W] ? SIZE_MAX : w_sum[SIZE_W-1:0];
                            n_found = 1'b1;
                        end
                    end else if (w_rd_live) begin
                        // pack down; slots left behind lie beyond the new count
                        w_we    = 1'b1;
                        w_waddr = r_wr[IDX_W-1:0];
                        w_wdata = w_rdata;
                        n_wr    = r_wr + 1'b1;
                    end
                end
                if (r_rd_addr < r_count) begin
                    n_pend     = 1'b1;
                    n_proc_idx = r_rd_addr[IDX_W-1:0];
                    n_rd_addr  = r_rd_addr + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_DONE;
                        if (r_is_del) begin
                            n_res_status = r_found ? ST_OK : ST_NOT_FOUND;
                        end else begin
                            n_count = r_wr;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_id     = r_res_id;
                    n_o_space  = r_free;
                    n_o_count  = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // capacity write empties the table
        if (i_cfg_valid) begin
            n_free  = i_cfg_data;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_free    <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_free    <= n_free;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
        r_is_del     <= n_is_del;
        r_key        <= n_key;
        r_rd_addr    <= n_rd_addr;
        r_proc_idx   <= n_proc_idx;
        r_wr         <= n_wr;
        r_found      <= n_found;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_o_status   <= n_o_status;
        r_o_id       <= n_o_id;
        r_o_space    <= n_o_space;
        r_o_count    <= n_o_count;
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_assigned_id = r_o_id;
    assign o_space_left  = r_o_space;
    assign o_entry_count = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_wr <= r_rd_addr))
        else $error("compaction write pointer ahead of read pointer");

    a_we_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_in_acc || (r_state == S_SCAN && r_pend)))
        else $error("entry write outside add or scan");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

endmodule

// ===== dv/ctf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_checker
// Watches the capacity, request and result channels of the file table. It
// keeps its own copy of the table, works out each result at request transfer
// and compares result transfers field by field in order.
// ----------------------------------------------------------------------------
module ctf_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [ctf_pkg::SIZE_W-1:0]          i_cfg_data,
    input  logic                                i_req_valid,
    input  logic                                i_req_ready,
    input  logic [ctf_pkg::KIND_W-1:0]          i_kind,
    input  logic [ctf_pkg::NAME_W-1:0]          i_name_key,
    input  logic [ctf_pkg::SIZE_W-1:0]          i_file_size,
    input  logic                                i_rsp_valid,
    input  logic                                i_rsp_ready,
    input  logic [ctf_pkg::STATUS_W-1:0]        i_status,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]    i_assigned_id,
    input  logic [ctf_pkg::SIZE_W-1:0]          i_space_left,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]    i_entry_count,
    output int                                  o_outstanding,
    output int                                  o_errors
);
    import ctf_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    id;
        logic [SIZE_W-1:0]   space;
        logic [CNT_W-1:0]    count;
    } t_file_result;

    logic [NAME_W-1:0] tbl_key  [TABLE_DEPTH];
    logic [SIZE_W-1:0] tbl_size [TABLE_DEPTH];
    logic [CNT_W-1:0]  tbl_id   [TABLE_DEPTH];
    logic              tbl_live [TABLE_DEPTH];
    logic [SIZE_W-1:0] capacity;
    logic [SIZE_W-1:0] free_units;
    int                used;
    t_file_result      awaited_results[$];

    function automatic void clear_table();
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            tbl_live[i] = 1'b0;
        end
        used       = 0;
        free_units = capacity;
    endfunction

    function automatic t_file_result apply_request(logic [KIND_W-1:0] kind,
                                                   logic [NAME_W-1:0] key,
                                                   logic [SIZE_W-1:0] size);
        t_file_result res;
        logic [SIZE_W:0] sum;
        int i;
        int wr;
        res        = '0;
        res.status = ST_OK;
        case (kind)
            KIND_ADD: begin
                // full table wins over lack of space
                if (used >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else if (size > free_units) begin
                    res.status = ST_NO_SPACE;
                end else begin
                    tbl_key[used]  = key;
                    tbl_size[used] = size;
                    tbl_id[used]   = CNT_W'(used + 1);
                    tbl_live[used] = 1'b1;
                    free_units     = free_units - size;
                    used           = used + 1;
                    res.id         = CNT_W'(used);
                end
            end
            KIND_DELETE: begin
                res.status = ST_NOT_FOUND;
                for (i = 0; i < used; i++) begin
                    if (tbl_live[i] && tbl_key[i] == key) begin
                        sum        = {1'b0, free_units} + {1'b0, tbl_size[i]};
                        free_units = sum > {1'b0, SIZE_MAX} ? SIZE_MAX : sum[SIZE_W-1:0];
                        tbl_live[i] = 1'b0;
                        res.status  = ST_OK;
                    end
                end
            end
            KIND_DEFRAG: begin
                // pack live entries down in order, ids kept
                wr = 0;
                for (i = 0; i < used; i++) begin
                    if (tbl_live[i]) begin
                        if (wr != i) begin
                            tbl_key[wr]  = tbl_key[i];
                            tbl_size[wr] = tbl_size[i];
                            tbl_id[wr]   = tbl_id[i];
                            tbl_live[wr] = 1'b1;
                            tbl_live[i]  = 1'b0;
                        end
                        wr++;
                    end
                end
                used = wr;
            end
            default: begin
            end
        endcase
        res.space = free_units;
        res.count = CNT_W'(used);
        return res;
    endfunction

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_file_result want;
        if (!i_rst_n) begin
            capacity = '0;
            clear_table();
            awaited_results.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                capacity = i_cfg_data;
                clear_table();
            end
            // the result leaving now is older than any request arriving now
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_results.size() == 0) begin
                    $display({"%0t: unexpected result, expected none, ",
                              "actual status %0d id %0d space %0d count %0d"},
                             $time, i_status, i_assigned_id, i_space_left, i_entry_count);
                    o_errors++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", want.status, i_status);
                    compare_field("assigned_id", want.id, i_assigned_id);
                    compare_field("space_left", want.space, i_space_left);
                    compare_field("entry_count", want.count, i_entry_count);
                end
            end
            if (i_req_valid && i_req_ready) begin
                awaited_results.push_back(apply_request(i_kind, i_name_key, i_file_size));
            end
        end
        o_outstanding = awaited_results.size();
    end

endmodule

// ===== dv/tb_contiguous_file_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_file_table
// Drives capacity writes and add, delete, defragment and unused-kind requests into the
// file table under changing backpressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_contiguous_file_table;
    import ctf_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = TABLE_DEPTH + 10;
    localparam int POOL_SIZE      = 8;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [SIZE_W-1:0]   i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    logic [KIND_W-1:0]   i_kind;
    logic [NAME_W-1:0]   i_name_key;
    logic [SIZE_W-1:0]   i_file_size;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [CNT_W-1:0]    o_assigned_id;
    logic [SIZE_W-1:0]   o_space_left;
    logic [CNT_W-1:0]    o_entry_count;

    int                  outstanding;
    int                  mismatches;
    int                  quiet_cycles;
    int                  tx_idle_pct;
    int                  rx_stall_pct;
    bit                  rx_hold;
    int                  rx_hold_cycles;
    logic [NAME_W-1:0]   key_pool [POOL_SIZE];

    contiguous_file_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (32)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_name_key    (i_name_key),
        .i_file_size   (i_file_size),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_assigned_id (o_assigned_id),
        .o_space_left  (o_space_left),
        .o_entry_count (o_entry_count)
    );

    ctf_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_kind        (i_kind),
        .i_name_key    (i_name_key),
        .i_file_size   (i_file_size),
        .i_rsp_valid   (o_valid),
        .i_rsp_ready   (i_ready),
        .i_status      (o_status),
        .i_assigned_id (o_assigned_id),
        .i_space_left  (o_space_left),
        .i_entry_count (o_entry_count),
        .o_outstanding (outstanding),
        .o_errors      (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold && !hold_done) begin
                i_ready = 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_ready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // drop the run if no channel has moved a transfer for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [NAME_W-1:0] key,
                                input logic [SIZE_W-1:0] size);
        int gap;
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_kind      = kind;
        i_name_key  = key;
        i_file_size = size;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold the request side until every result has come back
    task automatic wait_idle();
        i_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [SIZE_W-1:0] value);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [NAME_W-1:0] pick_key();
        if ($urandom_range(99) < 85) begin
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] cap);
        if ($urandom_range(99) < 10) begin
            return SIZE_W'($urandom);
        end
        return SIZE_W'($urandom_range(0, int'(cap) / 16 + 2));
    endfunction

    // runs of adds, a few deletes, sometimes a defragment, now and then noise
    task automatic run_sequences(input int n_items, input logic [SIZE_W-1:0] cap);
        int sent;
        int adds;
        int dels;
        int i;
        sent = 0;
        while (sent < n_items) begin
            adds = $urandom_range(1, 24);
            for (i = 0; i < adds; i++) begin
                send_request(KIND_ADD, pick_key(), pick_size(cap));
            end
            dels = $urandom_range(0, 4);
            for (i = 0; i < dels; i++) begin
                send_request(KIND_DELETE, pick_key(), SIZE_W'($urandom));
            end
            sent += adds + dels;
            if ($urandom_range(99) < 60) begin
                send_request(KIND_DEFRAG, $urandom, SIZE_W'($urandom));
                sent++;
            end
            if ($urandom_range(99) < 20) begin
                case ($urandom_range(2))
                    0:       send_request(KIND_UNUSED, $urandom, SIZE_W'($urandom));
                    1:       send_request(KIND_DELETE, $urandom, SIZE_W'($urandom));
                    default: send_request(KIND_ADD, $urandom, SIZE_W'($urandom));
                endcase
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] cap, input int tx_pct,
                             input int rx_pct, input int n_items);
        write_capacity(cap);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        run_sequences(n_items, cap);
    endtask

    initial begin
        int i;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_kind         = KIND_ADD;
        i_name_key     = '0;
        i_file_size    = '0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 30;
        rx_hold        = 1'b0;
        rx_hold_cycles = 0;
        for (i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero capacity after reset: only empty files fit
        send_request(KIND_ADD, 32'h0000_0000, 16'd0);
        send_request(KIND_ADD, 32'hFFFF_FFFF, 16'd1);
        send_request(KIND_DELETE, 32'h1234_5678, 16'd0);
        send_request(KIND_UNUSED, 32'h0000_0000, 16'd0);
        send_request(KIND_DELETE, 32'h0000_0000, 16'd0);
        send_request(KIND_DELETE, 32'h0000_0000, 16'd0);
        send_request(KIND_DEFRAG, 32'h0000_0000, 16'd0);

        // full capacity: exact fit, dead entries, repeated ids, compaction
        write_capacity(SIZE_MAX);
        send_request(KIND_ADD, 32'h0000_00A0, SIZE_MAX);
        send_request(KIND_ADD, 32'h0000_00B0, 16'd0);
        send_request(KIND_ADD, 32'h0000_00B0, 16'd1);
        send_request(KIND_ADD, 32'hFFFF_FFFF, 16'd0);
        send_request(KIND_DELETE, 32'h0000_00A0, 16'd0);
        send_request(KIND_ADD, 32'h0000_00B0, 16'd100);
        send_request(KIND_DELETE, 32'h0000_00B0, 16'd0);
        send_request(KIND_DELETE, 32'h0000_00B0, 16'd0);
        send_request(KIND_ADD, 32'h0000_00C0, SIZE_MAX);
        send_request(KIND_DEFRAG, 32'hFFFF_FFFF, SIZE_MAX);
        send_request(KIND_ADD, 32'h0000_00D0, 16'd0);
        send_request(KIND_DELETE, 32'hFFFF_FFFF, 16'd0);
        send_request(KIND_UNUSED, 32'hFFFF_FFFF, SIZE_MAX);

        // fill past the table depth to reach the full answer
        write_capacity(16'd300);
        tx_idle_pct  = 21;
        rx_stall_pct = 21;
        for (i = 0; i < TABLE_DEPTH + 6; i++) begin
            send_request(KIND_ADD, pick_key(), SIZE_W'($urandom_range(0, 3)));
        end

        run_phase(SIZE_MAX, 0, 0, 225);
        run_phase(16'd1000, 52, 0, 225);
        run_phase(16'd40, 0, 52, 225);
        run_phase(SIZE_W'($urandom), 21, 21, 225);
        run_phase(16'd0, 52, 52, 150);

        // long hold-off on results while requests keep coming
        write_capacity(SIZE_MAX);
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        rx_hold_cycles = 400;
        rx_hold        = 1'b1;
        run_sequences(60, SIZE_MAX);
        wait_idle();
        tx_idle_pct  = 21;
        rx_stall_pct = 21;
        run_sequences(100, SIZE_MAX);

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
